FILE: rtl/szba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szba_pkg
// Shared types and constants of the size class bitmap allocator.
// ----------------------------------------------------------------------------
package szba_pkg;

  // Geometry (MAX_BLOCKS is a multiple of the bitmap word width)
  localparam int NUM_CLASSES     = 13;
  localparam int MAX_BLOCKS      = 256;
  localparam int WORD_W          = 32;
  localparam int WORDS_PER_CLASS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int MAP_DEPTH       = NUM_CLASSES * WORDS_PER_CLASS;
  localparam int MAP_AW          = $clog2(MAP_DEPTH);
  localparam int WSEL_W          = (WORDS_PER_CLASS > 1) ? $clog2(WORDS_PER_CLASS) : 1;
  localparam int BIT_W           = $clog2(WORD_W);
  localparam int CLS_IDX_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  // Field widths fixed by the interface
  localparam int BYTES_W = 17;
  localparam int CLASS_W = 4;
  localparam int IDX_W   = 8;
  localparam int OFS_W   = 24;
  localparam int CNT_W   = 9;
  localparam int BSZ_W   = 17;

  localparam logic [BYTES_W-1:0] LARGEST_BLOCK = BYTES_W'(1 << 16);
  localparam logic [BSZ_W-1:0]   SMALLEST_BLOCK = BSZ_W'(16);
  localparam int                 NUM_THRESH     = 12;
  localparam logic [WORD_W-1:0]  TOP_BIT        = 32'h8000_0000;
  localparam logic [CNT_W-1:0]   CNT_FULL       = CNT_W'(MAX_BLOCKS);

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_OVERSIZE = 2'd2,
    ST_DFREE    = 2'd3
  } status_t;

  typedef struct packed {
    logic               req_type;
    logic [BYTES_W-1:0] req_bytes;
    logic [CLASS_W-1:0] free_class;
    logic [IDX_W-1:0]   free_index;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [CLASS_W-1:0] size_class;
    logic [IDX_W-1:0]   block_index;
    logic [OFS_W-1:0]   byte_offset;
    logic [CNT_W-1:0]   free_left;
  } out_item_t;

endpackage

FILE: rtl/size_class_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator
// Allocate/free engine over per-class free bitmaps held in a block RAM.
// ----------------------------------------------------------------------------
// One request at a time: start is taken when busy is low, and the answer
// appears on out_item for a single cycle with out_strobe high; the receiver
// cannot stall it, so capture it on that cycle. An allocation goes from S_DEC
// through S_EVAL, which reads k (1 to 8) bitmap words before a free block
// turns up, to S_MUL: the bitmap RAM has one read port and the scan reads
// one word per cycle, then S_MUL forms the byte offset in the multiplier.
// A free reads its word and writes it back unless the block is already
// free; oversize requests, out-of-range frees and classes whose count is
// zero answer from S_DEC without a bitmap read. A new start may be taken
// in the cycle the previous result is shown. No clearing pass is needed
// after reset: each bitmap word reads as all free until it is first written.
// ----------------------------------------------------------------------------
module size_class_bitmap_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  szba_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output szba_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  import szba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_EVAL = 4'b0100,
    S_MUL  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  in_item_t              req_r;
  logic [CLASS_W-1:0]    cls_r, cls_nxt;
  logic [WSEL_W-1:0]     wsel_r, wsel_nxt;
  logic [IDX_W-1:0]      blk_r, blk_nxt;
  logic [CNT_W-1:0]      left_r, left_nxt;
  logic                  out_vld_r, out_vld_nxt;
  out_item_t             out_r, out_nxt;
  logic                  chk_off_r;

  logic [CNT_W-1:0]      cnt_r [NUM_CLASSES];
  logic                  cnt_we;
  logic [CNT_W-1:0]      cnt_wdata;
  logic [CNT_W-1:0]      cnt_cur;

  logic [MAP_DEPTH-1:0]  vld_r;
  logic                  vld_q_r;

  logic                  ram_re, ram_we;
  logic [MAP_AW-1:0]     ram_raddr, ram_waddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;

  logic [CLASS_W-1:0]    cls_c;
  logic                  oversize_c;
  logic [WORD_W-1:0]     word_c;
  logic [BIT_W-1:0]      lead_c;
  logic                  any_c;
  logic [BIT_W-1:0]      fbit_c;
  logic [WORD_W-1:0]     fmask_c;
  logic [MAP_AW-1:0]     cur_addr_c;
  logic [BSZ_W-1:0]      bsz8_c;
  logic [BSZ_W+IDX_W-1:0] prod_c;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_vld_r;
  assign out_item   = out_r;

  // Bitmap store
  szba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Size class of an allocate: count the block sizes the request exceeds
  always_comb begin
    logic [CLASS_W:0] n;
    n = '0;
    for (int k = 0; k < NUM_THRESH; k++) begin
      if (req_r.req_bytes > BYTES_W'(SMALLEST_BLOCK << k)) begin
        n = n + 1'b1;
      end
    end
    oversize_c = (req_r.req_bytes > LARGEST_BLOCK) || (n >= (CLASS_W+1)'(NUM_CLASSES));
    cls_c      = n[CLASS_W-1:0];
  end

  // Current bitmap word; an unwritten word is all free
  assign word_c     = vld_q_r ? ram_rdata : '1;
  assign cur_addr_c = MAP_AW'(cls_r * WORDS_PER_CLASS + wsel_r);
  assign cnt_cur    = cnt_r[cls_r[CLS_IDX_W-1:0]];

  // Find the first free block, most significant bit first
  always_comb begin
    lead_c = '0;
    any_c  = 1'b0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!any_c && word_c[WORD_W-1-i]) begin
        lead_c = BIT_W'(i);
        any_c  = 1'b1;
      end
    end
  end

  assign fbit_c  = req_r.free_index[BIT_W-1:0];
  assign fmask_c = TOP_BIT >> fbit_c;

  // Offset multiply: block * (size + 8)
  assign bsz8_c = (SMALLEST_BLOCK << cls_r) + BSZ_W'(8);
  assign prod_c = blk_r * bsz8_c;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cls_nxt     = cls_r;
    wsel_nxt    = wsel_r;
    blk_nxt     = blk_r;
    left_nxt    = left_r;
    out_vld_nxt = 1'b0;
    out_nxt     = out_r;
    ram_re      = 1'b0;
    ram_raddr   = cur_addr_c;
    ram_we      = 1'b0;
    ram_waddr   = cur_addr_c;
    ram_wdata   = word_c;
    cnt_we      = 1'b0;
    cnt_wdata   = cnt_cur;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (req_r.req_type == REQ_ALLOC) begin
          if (oversize_c) begin
            out_nxt     = '{status: ST_OVERSIZE, default: '0};
            out_vld_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end else if (cnt_r[cls_c[CLS_IDX_W-1:0]] == '0) begin
            out_nxt            = '{status: ST_FULL, default: '0};
            out_nxt.size_class = cls_c;
            out_vld_nxt        = 1'b1;
            state_nxt          = S_IDLE;
          end else begin
            cls_nxt   = cls_c;
            wsel_nxt  = '0;
            ram_re    = 1'b1;
            ram_raddr = MAP_AW'(cls_c * WORDS_PER_CLASS);
            state_nxt = S_EVAL;
          end
        end else begin
          if ((req_r.free_class >= CLASS_W'(NUM_CLASSES)) ||
              ((IDX_W+1)'(req_r.free_index) >= (IDX_W+1)'(MAX_BLOCKS))) begin
            out_nxt             = '{status: ST_OK, default: '0};
            out_nxt.size_class  = req_r.free_class;
            out_nxt.block_index = req_r.free_index;
            out_vld_nxt         = 1'b1;
            state_nxt           = S_IDLE;
          end else begin
            cls_nxt   = req_r.free_class;
            wsel_nxt  = WSEL_W'(req_r.free_index >> BIT_W);
            ram_re    = 1'b1;
            ram_raddr = MAP_AW'(req_r.free_class * WORDS_PER_CLASS +
                                (req_r.free_index >> BIT_W));
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (req_r.req_type == REQ_ALLOC) begin
          if (any_c) begin
            // Take the block, write the word back, drop the count
            ram_we    = 1'b1;
            ram_wdata = word_c & ~(TOP_BIT >> lead_c);
            cnt_we    = 1'b1;
            cnt_wdata = cnt_cur - 1'b1;
            left_nxt  = cnt_cur - 1'b1;
            blk_nxt   = IDX_W'(wsel_r * WORD_W + lead_c);
            state_nxt = S_MUL;
          end else if (wsel_r == WSEL_W'(WORDS_PER_CLASS - 1)) begin
            out_nxt            = '{status: ST_FULL, default: '0};
            out_nxt.size_class = cls_r;
            out_vld_nxt        = 1'b1;
            state_nxt          = S_IDLE;
          end else begin
            // Advance to the next word of the class
            wsel_nxt  = wsel_r + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = cur_addr_c + 1'b1;
          end
        end else begin
          out_nxt             = '{status: ST_OK, default: '0};
          out_nxt.size_class  = cls_r;
          out_nxt.block_index = req_r.free_index;
          out_vld_nxt         = 1'b1;
          state_nxt           = S_IDLE;
          if ((word_c & fmask_c) != '0) begin
            out_nxt.status    = chk_off_r ? ST_OK : ST_DFREE;
            out_nxt.free_left = cnt_cur;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = word_c | fmask_c;
            cnt_we    = 1'b1;
            cnt_wdata = (cnt_cur < CNT_FULL) ? cnt_cur + 1'b1 : cnt_cur;
            out_nxt.free_left = cnt_wdata;
          end
        end
      end
      S_MUL: begin
        out_nxt             = '{status: ST_OK, default: '0};
        out_nxt.size_class  = cls_r;
        out_nxt.block_index = blk_r;
        out_nxt.byte_offset = OFS_W'(prod_c) + OFS_W'(8);
        out_nxt.free_left   = left_r;
        out_vld_nxt         = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      chk_off_r <= 1'b0;
      vld_r     <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_r[c] <= CNT_FULL;
      end
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        chk_off_r <= cfg_wdata;
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (cnt_we) begin
        cnt_r[cls_r[CLS_IDX_W-1:0]] <= cnt_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_item;
    end
    if (ram_re) begin
      vld_q_r <= vld_r[ram_raddr];
    end
    cls_r  <= cls_nxt;
    wsel_r <= wsel_nxt;
    blk_r  <= blk_nxt;
    left_r <= left_nxt;
    out_r  <= out_nxt;
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register not one-hot");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_re && ram_we)) else $error("bitmap read and write in one cycle");

  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DEC)) else $error("accepted beat not decoded");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ($past(state_r) != S_IDLE)) else $error("result beat without a request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (cnt_cur <= CNT_FULL)) else $error("free count above capacity");

endmodule

FILE: rtl/szba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szba_ram
// Generic one-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module szba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
